// File: hdl/hsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed tag cache package
// Shared constants, types and hash helpers for the hashed LRU tag cache.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int DEF_SETS       = 64;
    localparam int DEF_WAYS       = 4;
    localparam int DEF_STAMP_BITS = 32;

    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [31:0] MIX_C1    = 32'h85EBCA6B;
    localparam logic [31:0] MIX_C2    = 32'hC2B2AE35;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DECIDE,
        BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [39:0] key_c;
        logic        shade_present;
        logic [31:0] shade_key;
        logic [31:0] hash;
    } req_t;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage
`default_nettype wire

// File: hdl/hsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed tag cache front end
// Accepts lookups, hashes the key one byte per cycle and queues the request.
// ----------------------------------------------------------------------------
module hsc_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [63:0]   key_a,
    input  wire logic [63:0]   key_b,
    input  wire logic [39:0]   key_c,
    input  wire logic          shade_present,
    input  wire logic [31:0]   shade_key,
    output logic               q_valid,
    input  wire logic          q_ready,
    output hsc_pkg::req_t      q_data
);
    import hsc_pkg::*;

    logic          busy_reg, busy_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [2:0]    mix_reg, mix_next;
    logic [31:0]   h_reg, h_next;
    logic [167:0]  bytes_reg, bytes_next;
    req_t          cur_reg, cur_next;
    req_t          fifo_reg [2];
    logic [1:0]    fcnt_reg, fcnt_next;
    logic          push;
    logic          pop;
    logic          push_first;
    req_t          push_data;
    logic [7:0]    cur_byte;

    assign cur_byte   = bytes_reg[167:160];
    assign in_ready   = !busy_reg;
    assign pop        = q_valid && q_ready;
    assign push       = busy_reg && (mix_reg == 3'd5) && (fcnt_reg != 2'd2 || pop);
    assign push_first = (fcnt_reg == 2'd0) || (fcnt_reg == 2'd1 && pop);
    assign q_valid    = fcnt_reg != 2'd0;
    assign q_data     = fifo_reg[0];

    always_comb
    begin
        push_data      = cur_reg;
        push_data.hash = h_reg;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        mix_next   = mix_reg;
        h_next     = h_reg;
        bytes_next = bytes_reg;
        cur_next   = cur_reg;
        if (in_valid && in_ready)
        begin
            busy_next  = 1'b1;
            cnt_next   = 5'd0;
            mix_next   = 3'd0;
            h_next     = FNV_BASIS;
            bytes_next = {key_a[55:48], key_a[63:56], key_a[47:0], key_b, key_c};
            cur_next.key_a         = key_a;
            cur_next.key_b         = key_b;
            cur_next.key_c         = key_c;
            cur_next.shade_present = shade_present;
            cur_next.shade_key     = shade_key;
            cur_next.hash          = 32'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 5'd21)
            begin
                h_next     = fnv_step(h_reg, cur_byte);
                bytes_next = {bytes_reg[159:0], 8'd0};
                cnt_next   = cnt_reg + 5'd1;
            end
            else
            begin
                case (mix_reg)
                    3'd0: h_next = h_reg ^ {16'd0, h_reg[31:16]};
                    3'd1: h_next = h_reg * MIX_C1;
                    3'd2: h_next = h_reg ^ {13'd0, h_reg[31:13]};
                    3'd3: h_next = h_reg * MIX_C2;
                    3'd4: h_next = h_reg ^ {16'd0, h_reg[31:16]};
                    default: h_next = h_reg;
                endcase
                if (mix_reg != 3'd5)
                begin
                    mix_next = mix_reg + 3'd1;
                end
                else if (push)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        fcnt_next = fcnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fcnt_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            fcnt_reg <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        mix_reg   <= mix_next;
        h_reg     <= h_next;
        bytes_reg <= bytes_next;
        cur_reg   <= cur_next;
        if (push && push_first)
        begin
            fifo_reg[0] <= push_data;
        end
        else if (pop)
        begin
            fifo_reg[0] <= fifo_reg[1];
        end
        if (push && !push_first)
        begin
            fifo_reg[1] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed tag cache back end
// Reads one set, picks the way, writes tags and stamps, and holds the result.
// ----------------------------------------------------------------------------
module hsc_back
#(
    parameter int SETS       = hsc_pkg::DEF_SETS,
    parameter int WAYS       = hsc_pkg::DEF_WAYS,
    parameter int STAMP_BITS = hsc_pkg::DEF_STAMP_BITS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire hsc_pkg::req_t q_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               hit,
    output logic [5:0]         set_index,
    output logic [1:0]         way_index,
    output logic               evicted,
    output logic               relit,
    output logic [31:0]        hit_count,
    output logic [31:0]        miss_count,
    output logic [31:0]        eviction_count,
    output logic [31:0]        relight_count
);
    import hsc_pkg::*;

    localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = SETS * WAYS;
    localparam int LB    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW    = 64 + 64 + 40 + STAMP_BITS + 32;

    bk_state_t st_reg, st_next;
    logic [SLOTS-1:0] ev_reg, sv_reg;
    logic [TW-1:0] mem [SETS][WAYS];
    logic [TW-1:0] rd_reg [WAYS];
    req_t req_reg;
    logic [SB-1:0] set_reg;
    logic [STAMP_BITS-1:0] clk_reg;
    logic [31:0] ht_reg, mt_reg, et_reg, rt_reg;
    logic hit_reg, evi_reg, rel_reg;
    logic [WB-1:0] way_reg;
    logic [SB-1:0] set_calc;
    logic          wr_en;
    logic [TW-1:0] wr_data;

    logic [WB-1:0] sel_way;
    logic          sel_hit;
    logic          sel_ev;
    logic          sel_rel;
    logic          new_sv;
    logic [31:0]   new_shade;

    assign set_calc = SB'(q_data.hash % SETS);
    assign q_ready  = (st_reg == BK_IDLE);

    always_comb
    begin
        logic found, fr;
        logic [STAMP_BITS-1:0] best, age;
        logic bv;
        logic [WB-1:0] fw, ow;
        logic [LB-1:0] i;
        logic [TW-1:0] e;
        found = 1'b0; fr = 1'b0; bv = 1'b0;
        best = '0; fw = '0; ow = '0; sel_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            i = LB'(set_reg) * LB'(WAYS) + LB'(w);
            e = rd_reg[w];
            age = clk_reg - e[32 +: STAMP_BITS];
            if (!found)
            begin
                if (ev_reg[i] && e[TW-1-:64] == req_reg.key_a
                    && e[TW-65-:64] == req_reg.key_b && e[TW-129-:40] == req_reg.key_c)
                begin
                    found = 1'b1;
                    sel_way = WB'(w);
                end
                else if (!ev_reg[i])
                begin
                    if (!fr)
                    begin
                        fr = 1'b1;
                        fw = WB'(w);
                    end
                end
                else if (!bv || age > best)
                begin
                    bv = 1'b1;
                    best = age;
                    ow = WB'(w);
                end
            end
        end
        if (!found)
        begin
            sel_way = fr ? fw : ow;
        end
        sel_hit = found;
    end

    always_comb
    begin
        logic [LB-1:0] s;
        logic cur_sv;
        s = LB'(set_reg) * LB'(WAYS) + LB'(sel_way);
        sel_ev = !sel_hit && ev_reg[s];
        cur_sv = sel_hit && sv_reg[s];
        sel_rel = 1'b0;
        new_sv = cur_sv;
        new_shade = rd_reg[sel_way][31:0];
        if (req_reg.shade_present
            && (!cur_sv || rd_reg[sel_way][31:0] != req_reg.shade_key))
        begin
            sel_rel = cur_sv;
            new_shade = req_reg.shade_key;
            new_sv = 1'b1;
        end
        wr_data = {req_reg.key_a, req_reg.key_b, req_reg.key_c, clk_reg, new_shade};
        wr_en = (st_reg == BK_DECIDE);
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:   if (q_valid) st_next = BK_READ;
            BK_READ:   st_next = BK_DECIDE;
            BK_DECIDE: st_next = BK_OUT;
            BK_OUT:    if (out_ready) st_next = BK_IDLE;
            default:   st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid = (st_reg == BK_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= BK_IDLE;
            ev_reg  <= '0;
            sv_reg  <= '0;
            clk_reg <= '0;
            ht_reg  <= '0;
            mt_reg  <= '0;
            et_reg  <= '0;
            rt_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == BK_IDLE && q_valid)
            begin
                clk_reg <= clk_reg + 1'b1;
            end
            if (wr_en)
            begin
                ev_reg[LB'(set_reg) * LB'(WAYS) + LB'(sel_way)] <= 1'b1;
                sv_reg[LB'(set_reg) * LB'(WAYS) + LB'(sel_way)] <= new_sv;
                ht_reg <= ht_reg + {31'd0, sel_hit};
                mt_reg <= mt_reg + {31'd0, !sel_hit};
                et_reg <= et_reg + {31'd0, sel_ev};
                rt_reg <= rt_reg + {31'd0, sel_rel};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && q_valid)
        begin
            req_reg <= q_data;
            set_reg <= set_calc;
        end
        if (st_reg == BK_READ)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                rd_reg[w] <= mem[set_reg][w];
            end
        end
        if (wr_en)
        begin
            mem[set_reg][sel_way] <= wr_data;
            hit_reg <= sel_hit;
            way_reg <= sel_way;
            evi_reg <= sel_ev;
            rel_reg <= sel_rel;
        end
    end

    assign hit            = hit_reg;
    assign set_index      = 6'(set_reg);
    assign way_index      = 2'(way_reg);
    assign evicted        = evi_reg;
    assign relit          = rel_reg;
    assign hit_count      = ht_reg;
    assign miss_count     = mt_reg;
    assign eviction_count = et_reg;
    assign relight_count  = rt_reg;

endmodule
`default_nettype wire

// File: hdl/hashed_set_assoc_lru_tag_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed set-associative LRU tag cache
// Front end hashes and queues lookups; back end updates the selected set.
// ----------------------------------------------------------------------------
// The front end hashes a lookup beat one key byte per cycle and then runs the
// finalizer; the back end reads the set, chooses the way, writes it and then
// holds the result beat. A two-entry queue between them lets the next key hash
// while the previous set is updated, so the sustained rate is set by the
// byte-serial hash unless the result channel stalls.
module hashed_set_assoc_lru_tag_cache
#(
    parameter int SETS       = hsc_pkg::DEF_SETS,
    parameter int WAYS       = hsc_pkg::DEF_WAYS,
    parameter int STAMP_BITS = hsc_pkg::DEF_STAMP_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] key_a,
    input  wire logic [63:0] key_b,
    input  wire logic [39:0] key_c,
    input  wire logic        shade_present,
    input  wire logic [31:0] shade_key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic [5:0]       set_index,
    output logic [1:0]       way_index,
    output logic             evicted,
    output logic             relit,
    output logic [31:0]      hit_count,
    output logic [31:0]      miss_count,
    output logic [31:0]      eviction_count,
    output logic [31:0]      relight_count
);
    import hsc_pkg::*;

    logic q_valid, q_ready;
    req_t q_data;

    hsc_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .key_a(key_a), .key_b(key_b), .key_c(key_c),
        .shade_present(shade_present), .shade_key(shade_key),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    hsc_back #(.SETS(SETS), .WAYS(WAYS), .STAMP_BITS(STAMP_BITS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .set_index(set_index), .way_index(way_index),
        .evicted(evicted), .relit(relit), .hit_count(hit_count),
        .miss_count(miss_count), .eviction_count(eviction_count),
        .relight_count(relight_count)
    );

endmodule
`default_nettype wire

// File: hdl/hsc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed tag cache checker
// Port-level checks on the result beats of the tag cache.
// ----------------------------------------------------------------------------
module hsc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic        evicted,
    input wire logic [31:0] hit_count
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_count))
        else $error("result beat dropped");

    a_hit_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit with eviction");

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> $stable(hit_count) || out_valid)
        else $error("hit count moved without a result");

endmodule

bind hashed_set_assoc_lru_tag_cache hsc_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .evicted(evicted), .hit_count(hit_count)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed tag cache testbench
// Drives lookups with random idle gaps on both channels, predicts each result
// with a cycle-free model of the hashed set-associative LRU cache, and checks
// every result beat in order, comparing all of its fields at once.
// ----------------------------------------------------------------------------
module tb_top;

    import hsc_pkg::*;

    localparam int N_SETS  = DEF_SETS;
    localparam int N_WAYS  = DEF_WAYS;
    localparam int N_SLOTS = N_SETS * N_WAYS;

    typedef struct packed {
        logic        hit;
        logic [5:0]  set_index;
        logic [1:0]  way_index;
        logic        evicted;
        logic        relit;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
        logic [31:0] relight_count;
    } lookup_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [39:0] key_c;
    logic        shade_present;
    logic [31:0] shade_key;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [5:0]  set_index;
    logic [1:0]  way_index;
    logic        evicted;
    logic        relit;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [31:0] relight_count;

    logic        line_valid [N_SLOTS];
    logic        tint_valid [N_SLOTS];
    logic [31:0] line_stamp [N_SLOTS];
    logic [63:0] line_a [N_SLOTS];
    logic [63:0] line_b [N_SLOTS];
    logic [39:0] line_c [N_SLOTS];
    logic [31:0] line_tint [N_SLOTS];
    logic [31:0] stamp_now;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
    logic [31:0] evicts_so_far;
    logic [31:0] relights_so_far;

    lookup_result_t pending_results[$];
    logic [63:0]    seen_a[$];
    logic [63:0]    seen_b[$];
    logic [39:0]    seen_c[$];
    int             mismatches;
    bit             stimulus_done;

    hashed_set_assoc_lru_tag_cache dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .key_a          (key_a),
        .key_b          (key_b),
        .key_c          (key_c),
        .shade_present  (shade_present),
        .shade_key      (shade_key),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .set_index      (set_index),
        .way_index      (way_index),
        .evicted        (evicted),
        .relit          (relit),
        .hit_count      (hit_count),
        .miss_count     (miss_count),
        .eviction_count (eviction_count),
        .relight_count  (relight_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] key_digest(logic [63:0] a, logic [63:0] b,
                                               logic [39:0] c);
        logic [31:0] h;
        logic [7:0]  bytes [21];
        h = 32'h811C9DC5;
        bytes[0] = a[55:48];
        bytes[1] = a[63:56];
        for (int i = 0; i < 6; i++)
            bytes[2 + i] = a[47 - 8 * i -: 8];
        for (int i = 0; i < 8; i++)
            bytes[8 + i] = b[63 - 8 * i -: 8];
        for (int i = 0; i < 5; i++)
            bytes[16 + i] = c[39 - 8 * i -: 8];
        for (int i = 0; i < 21; i++)
            h = (h ^ {24'd0, bytes[i]}) * 32'd16777619;
        h = h ^ (h >> 16);
        h = h * 32'h85EBCA6B;
        h = h ^ (h >> 13);
        h = h * 32'hC2B2AE35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic lookup_result_t cache_lookup(logic [63:0] a, logic [63:0] b,
                                                    logic [39:0] c, logic sp,
                                                    logic [31:0] sk);
        lookup_result_t r;
        int          set_no;
        int          found;
        int          free_way;
        int          old_way;
        int          slot;
        logic [31:0] age;
        logic [31:0] old_age;
        found = -1;
        free_way = -1;
        old_way = -1;
        old_age = 0;
        r = '0;
        stamp_now = stamp_now + 1;
        set_no = key_digest(a, b, c) % N_SETS;
        for (int w = 0; w < N_WAYS; w++)
        begin
            slot = set_no * N_WAYS + w;
            if (found < 0)
            begin
                if (line_valid[slot] && line_a[slot] == a && line_b[slot] == b
                    && line_c[slot] == c)
                    found = w;
                else if (!line_valid[slot])
                begin
                    if (free_way < 0)
                        free_way = w;
                end
                else
                begin
                    age = stamp_now - line_stamp[slot];
                    if (old_way < 0 || age > old_age)
                    begin
                        old_way = w;
                        old_age = age;
                    end
                end
            end
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            r.way_index = found[1:0];
            hits_so_far++;
        end
        else
        begin
            found = (free_way >= 0) ? free_way : ((old_way >= 0) ? old_way : 0);
            r.way_index = found[1:0];
            slot = set_no * N_WAYS + found;
            if (line_valid[slot])
            begin
                r.evicted = 1'b1;
                evicts_so_far++;
            end
            line_valid[slot] = 1'b1;
            tint_valid[slot] = 1'b0;
            line_a[slot] = a;
            line_b[slot] = b;
            line_c[slot] = c;
            misses_so_far++;
        end
        slot = set_no * N_WAYS + found;
        line_stamp[slot] = stamp_now;
        if (sp && (!tint_valid[slot] || line_tint[slot] != sk))
        begin
            if (tint_valid[slot])
            begin
                r.relit = 1'b1;
                relights_so_far++;
            end
            line_tint[slot] = sk;
            tint_valid[slot] = 1'b1;
        end
        r.set_index = set_no[5:0];
        r.hit_count = hits_so_far;
        r.miss_count = misses_so_far;
        r.eviction_count = evicts_so_far;
        r.relight_count = relights_so_far;
        return r;
    endfunction

    task automatic send_lookup(logic [63:0] a, logic [63:0] b, logic [39:0] c,
                               logic sp, logic [31:0] sk);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_a <= a;
        key_b <= b;
        key_c <= c;
        shade_present <= sp;
        shade_key <= sk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(cache_lookup(a, b, c, sp, sk));
        seen_a.push_back(a);
        seen_b.push_back(b);
        seen_c.push_back(c);
        if (seen_a.size() > 64)
        begin
            void'(seen_a.pop_front());
            void'(seen_b.pop_front());
            void'(seen_c.pop_front());
        end
    endtask

    task automatic send_repeat(logic sp, logic [31:0] sk);
        int k;
        k = $urandom_range(0, seen_a.size() - 1);
        send_lookup(seen_a[k], seen_b[k], seen_c[k], sp, sk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_field_extremes();
        send_lookup('0, '0, '0, 1'b0, '0);
        send_lookup('1, '1, '1, 1'b1, '1);
        send_lookup('0, '0, '0, 1'b1, '0);
        send_lookup('1, '1, '1, 1'b1, 32'h0);
        send_lookup('1, '1, '1, 1'b1, 32'h0);
        send_lookup('1, '1, '1, 1'b0, 32'h1234);
        send_lookup(64'h8000_0000_0000_0001, 64'h5555_AAAA_5555_AAAA,
                    40'hAA_5555_AAAA, 1'b0, '0);
    endtask

    task automatic test_set_fill_and_evict();
        logic [63:0] a;
        logic [63:0] b;
        logic [39:0] c;
        logic [5:0]  target;
        int          found_n;
        target = 6'(key_digest('0, '0, '0) % N_SETS);
        found_n = 0;
        while (found_n < 6)
        begin
            a = rand64();
            b = rand64();
            c = 40'(rand64());
            if (key_digest(a, b, c) % N_SETS == target)
            begin
                send_lookup(a, b, c, 1'b1, $urandom);
                found_n++;
            end
        end
        send_lookup('0, '0, '0, 1'b1, 32'h77);
        send_lookup('0, '0, '0, 1'b1, 32'h78);
    endtask

    task automatic test_random_traffic(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5 && seen_a.size() > 0)
                send_repeat(1'($urandom_range(0, 1)), $urandom_range(0, 3));
            else if (pick < 7)
                send_lookup({48'd0, 16'($urandom_range(0, 255))}, '0, '0,
                            1'($urandom_range(0, 1)), $urandom_range(0, 1));
            else
                send_lookup(rand64(), rand64(), 40'(rand64()),
                            1'($urandom_range(0, 1)), $urandom);
        end
    endtask

    initial
    begin : results_check
        lookup_result_t want;
        lookup_result_t got;
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{hit, set_index, way_index, evicted, relit, hit_count,
                        miss_count, eviction_count, relight_count};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p actual %p", want, got);
                    end
                end
                stall = $urandom_range(0, 17);
            end
            else if (stall > 0)
            begin
                stall--;
            end
            out_ready <= (stall == 0);
        end
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < N_SLOTS; i++)
        begin
            line_valid[i] = 1'b0;
            tint_valid[i] = 1'b0;
        end
        stamp_now = 0;
        hits_so_far = 0;
        misses_so_far = 0;
        evicts_so_far = 0;
        relights_so_far = 0;
        mismatches = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        key_a = '0;
        key_b = '0;
        key_c = '0;
        shade_present = 1'b0;
        shade_key = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_set_fill_and_evict();
        test_random_traffic(1250);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
